### sv/smbw_pkg.sv
// Shared types and constants for the SMBIOS structure table walker.
package smbw_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 16;

  // Result queue: an item yields at most two results.
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned MAX_RES    = 2;

  // Configuration register indexes.
  localparam logic [7:0] REG_TARGET_TYPE  = 8'd0;
  localparam logic [7:0] REG_STRING_INDEX = 8'd1;

  typedef enum logic [1:0] {
    KIND_STRUCT_FOUND   = 2'd0,
    KIND_STRING_FOUND   = 2'd1,
    KIND_STRING_ABSENT  = 2'd2,
    KIND_STRUCT_MISSING = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] offset;
    logic        final_res;
  } result_t;

  // Results produced by one processed byte.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } step_out_t;

  typedef struct packed {
    logic [FIFO_PTR_W:0] count;
  } fifo_stat_t;

endpackage

### sv/smbw_walker.sv
// Table walk state and per-byte decision logic.
module smbw_walker #(
  parameter int unsigned OFFSET_BITS = smbw_pkg::OFFSET_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  logic [7:0]          target_type_i,
  input  logic [7:0]          string_index_i,
  output smbw_pkg::step_out_t out_o
);

  localparam logic [2:0] PH_TYPE      = 3'd0;
  localparam logic [2:0] PH_LENGTH    = 3'd1;
  localparam logic [2:0] PH_FORMATTED = 3'd2;
  localparam logic [2:0] PH_STRINGS   = 3'd3;
  localparam logic [2:0] PH_DONE      = 3'd4;

  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [2:0]             phase_q, phase_d;
  logic [7:0]             fmt_left_q, fmt_left_d;
  logic                   prev_zero_q, prev_zero_d;
  logic [7:0]             str_cnt_q, str_cnt_d;
  logic                   in_match_q, in_match_d;
  logic                   found_q, found_d;
  logic                   done_q, done_d;

  logic [OFFSET_BITS+15:0] pos_ext;
  logic [15:0]             pos16;
  logic [7:0]              cnt_inc;
  logic                    is_zero;
  smbw_pkg::step_out_t     out;

  assign pos_ext = {16'd0, pos_q};
  assign pos16   = pos_ext[15:0];
  assign is_zero = (byte_i == 8'd0);
  assign cnt_inc = (prev_zero_q && str_cnt_q != 8'hFF) ? str_cnt_q + 8'd1 : str_cnt_q;

  always_comb begin
    pos_d       = pos_q + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
    phase_d     = phase_q;
    fmt_left_d  = fmt_left_q;
    prev_zero_d = prev_zero_q;
    str_cnt_d   = str_cnt_q;
    in_match_d  = in_match_q;
    found_d     = found_q;
    done_d      = done_q;
    out         = '0;
    out.r0.final_res = 1'b1;
    out.r1.final_res = 1'b1;

    if (last_i) begin
      if (!found_q) begin
        if (phase_q == PH_TYPE && byte_i == target_type_i) begin
          // match on the final byte: header seen, no string set follows
          out.n            = 2'd2;
          out.r0.kind      = smbw_pkg::KIND_STRUCT_FOUND;
          out.r0.offset    = pos16;
          out.r0.final_res = 1'b0;
          out.r1.kind      = smbw_pkg::KIND_STRING_ABSENT;
        end else begin
          out.n       = 2'd1;
          out.r0.kind = smbw_pkg::KIND_STRUCT_MISSING;
        end
      end else if (!done_q) begin
        out.n       = 2'd1;
        out.r0.kind = smbw_pkg::KIND_STRING_ABSENT;
      end
      // next byte opens a new table
      pos_d       = '0;
      phase_d     = PH_TYPE;
      fmt_left_d  = 8'd0;
      prev_zero_d = 1'b0;
      str_cnt_d   = 8'd1;
      in_match_d  = 1'b0;
      found_d     = 1'b0;
      done_d      = 1'b0;
    end else begin
      case (phase_q)
        PH_TYPE: begin
          if (!found_q && byte_i == target_type_i) begin
            out.n         = 2'd1;
            out.r0.kind   = smbw_pkg::KIND_STRUCT_FOUND;
            out.r0.offset = pos16;
            found_d       = 1'b1;
            in_match_d    = 1'b1;
          end else begin
            in_match_d = 1'b0;
          end
          phase_d = PH_LENGTH;
        end
        PH_LENGTH: begin
          // length counts the 2-byte header; short lengths act as 2
          fmt_left_d  = (byte_i > 8'd2) ? byte_i - 8'd2 : 8'd0;
          phase_d     = (byte_i > 8'd2) ? PH_FORMATTED : PH_STRINGS;
          prev_zero_d = 1'b0;
          str_cnt_d   = 8'd1;
        end
        PH_FORMATTED: begin
          fmt_left_d = fmt_left_q - 8'd1;
          if (fmt_left_q == 8'd1) begin
            phase_d = PH_STRINGS;
          end
        end
        PH_STRINGS: begin
          if (in_match_q) begin
            if (prev_zero_q && is_zero) begin
              out.n       = 2'd1;
              out.r0.kind = smbw_pkg::KIND_STRING_ABSENT;
              done_d      = 1'b1;
              phase_d     = PH_DONE;
            end else begin
              str_cnt_d = cnt_inc;
              if (cnt_inc == string_index_i) begin
                out.n         = 2'd1;
                out.r0.kind   = smbw_pkg::KIND_STRING_FOUND;
                out.r0.offset = pos16;
                done_d        = 1'b1;
                phase_d       = PH_DONE;
              end else begin
                prev_zero_d = is_zero;
              end
            end
          end else begin
            if (prev_zero_q && is_zero) begin
              phase_d = PH_TYPE;
            end else begin
              prev_zero_d = is_zero;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      phase_q     <= PH_TYPE;
      fmt_left_q  <= 8'd0;
      prev_zero_q <= 1'b0;
      str_cnt_q   <= 8'd1;
      in_match_q  <= 1'b0;
      found_q     <= 1'b0;
      done_q      <= 1'b0;
    end else if (step_i) begin
      pos_q       <= pos_d;
      phase_q     <= phase_d;
      fmt_left_q  <= fmt_left_d;
      prev_zero_q <= prev_zero_d;
      str_cnt_q   <= str_cnt_d;
      in_match_q  <= in_match_d;
      found_q     <= found_d;
      done_q      <= done_d;
    end
  end

  always_comb begin
    out_o = out;
    if (!step_i) begin
      out_o.n = 2'd0;
    end
  end

endmodule

### sv/smbw_fifo.sv
// Result queue: takes up to two results a cycle, hands out one a cycle when popped.
module smbw_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  smbw_pkg::step_out_t  push_i,
  input  logic                 pop_i,
  output smbw_pkg::result_t    head_o,
  output logic                 valid_o,
  output smbw_pkg::fifo_stat_t stat_o
);

  localparam int unsigned PW = smbw_pkg::FIFO_PTR_W;

  smbw_pkg::result_t mem_q [smbw_pkg::FIFO_DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [PW:0]       count_q, count_d;
  logic [PW-1:0]     wr_ptr_p1;
  logic              do_pop;

  assign valid_o   = (count_q != '0);
  assign do_pop    = pop_i && valid_o;
  assign head_o    = mem_q[rd_ptr_q];
  assign wr_ptr_p1 = wr_ptr_q + {{(PW-1){1'b0}}, 1'b1};

  always_comb begin
    wr_ptr_d = wr_ptr_q + {{(PW-2){1'b0}}, push_i.n};
    rd_ptr_d = do_pop ? rd_ptr_q + {{(PW-1){1'b0}}, 1'b1} : rd_ptr_q;
    count_d  = count_q + {{(PW-1){1'b0}}, push_i.n} - {{PW{1'b0}}, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_p1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign stat_o.count = count_q;

endmodule

### sv/smbios_structure_walker.sv
// Top level of the SMBIOS structure table walker.
//
// s_axis: one table byte per beat, tdata[7:0] = table_byte, tlast marks the
//   final byte of the table; a new table starts on the beat after tlast.
// m_axis: result beats; tuser = kind (0 structure found, 1 string found,
//   2 string absent, 3 structure not found), tdata[15:0] = offset,
//   tlast = final result caused by that input byte. A byte causes 0..2 results.
// cfg: index 0 = target_type, 1 = string_index; always ready. Write only
//   while the walker is idle; a new value applies to the next byte.
// Path: a taken byte sits in the input register, its results are
//   registered into the queue and result beats leave from the queue head.
// Throughput: one byte per cycle while s_axis_tready is high; the input
//   register feeds the walk logic and the 8-entry result queue absorbs bursts.
// Reset: clears the walk state, the queue and the input stage;
//   target_type = 0, string_index = 1.
// Stall: with m_axis stalled the queue fills; s_axis_tready drops once more
//   than four results are waiting, so a byte in flight never overruns it.
module smbios_structure_walker #(
  parameter int unsigned OFFSET_BITS = smbw_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input bytes
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] table_byte
  input  logic        s_axis_tlast_i,   // last_byte
  // results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] offset
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o,   // final_res
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  // worst case in flight: two results from the byte in the input stage
  // plus two from the byte being accepted
  localparam int unsigned READY_LIMIT = smbw_pkg::FIFO_DEPTH - 2 * smbw_pkg::MAX_RES;

  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic                 in_last_q;
  logic                 in_beat;
  logic [7:0]           target_type_q;
  logic [7:0]           string_index_q;
  smbw_pkg::step_out_t  step_out;
  smbw_pkg::result_t    head;
  smbw_pkg::fifo_stat_t fifo_stat;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (fifo_stat.count <= READY_LIMIT[smbw_pkg::FIFO_PTR_W:0]);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_type_q  <= 8'd0;
      string_index_q <= 8'd1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == smbw_pkg::REG_TARGET_TYPE) begin
        target_type_q <= cfg_data_i;
      end
      if (cfg_index_i == smbw_pkg::REG_STRING_INDEX) begin
        string_index_q <= cfg_data_i;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_beat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  smbw_walker #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_walker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (in_valid_q),
    .byte_i         (in_byte_q),
    .last_i         (in_last_q),
    .target_type_i  (target_type_q),
    .string_index_i (string_index_q),
    .out_o          (step_out)
  );

  smbw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step_out),
    .pop_i   (m_axis_tready_i),
    .head_o  (head),
    .valid_o (m_axis_tvalid_o),
    .stat_o  (fifo_stat)
  );

  assign m_axis_tdata_o = head.offset;
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.final_res;

  // queue never holds more than its depth
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.count <= smbw_pkg::FIFO_DEPTH[smbw_pkg::FIFO_PTR_W:0])
    else $error("result queue overflow");

  // only the final table byte can produce two results
  a_two_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && step_out.n == 2'd2) |-> in_last_q)
    else $error("two results from a non-final byte");

  // a single result always closes its byte
  a_single_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_out.n == 2'd1) |-> step_out.r0.final_res)
    else $error("single result without final mark");

  // a two-result byte marks only the second one final
  a_pair_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_out.n == 2'd2) |-> (!step_out.r0.final_res && step_out.r1.final_res))
    else $error("bad final marks on result pair");

endmodule

### tb/tb_smbios_structure_walker.sv
// Self-checking testbench for the SMBIOS structure table walker: directed and random tables.
module tb_smbios_structure_walker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RANDOM_BYTES  = 950;
  // a byte's results reach the result queue after the input register; margin on top
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef enum logic [2:0] {
    WALK_TYPE, WALK_LENGTH, WALK_FORMATTED, WALK_STRINGS, WALK_DONE
  } walk_phase_e;

  // one directed step: a register write or a table byte
  typedef struct {
    bit              is_cfg;
    logic [7:0]      a;         // register index or table byte
    logic [7:0]      d;         // write data
    logic            last;
    int              n_typed;   // -1: predicted, else number of typed results
    smbw_pkg::kind_e k0;
    logic [15:0]     o0;
    smbw_pkg::kind_e k1;
  } dir_row_t;

  typedef struct {
    smbw_pkg::kind_e kind;
    logic [15:0]     offset;
  } hit_t;

  // ---------------------------------------------------------------------------
  // DUT signals, all known from time zero
  // ---------------------------------------------------------------------------
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i     = '0;
  logic [7:0]  cfg_data_i      = '0;

  smbios_structure_walker uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Walk predictor: mirrors the walker state and both registers
  // ---------------------------------------------------------------------------
  logic [7:0]  target_type_q  = 8'd0;
  logic [7:0]  string_index_q = 8'd1;
  logic [15:0] walk_pos       = '0;
  walk_phase_e walk_phase     = WALK_TYPE;
  logic [7:0]  fmt_left       = '0;
  logic        prev_zero      = 1'b0;
  logic [7:0]  string_count   = 8'd1;
  logic        in_match       = 1'b0;
  logic        struct_found   = 1'b0;
  logic        string_done    = 1'b0;

  hit_t              byte_hits[$];          // results of the byte being predicted
  smbw_pkg::result_t expected_results[$];   // in arrival order
  int unsigned       errors         = 0;
  int unsigned       cycle_count    = 0;
  int unsigned       fed_bytes      = 0;    // bytes sent in the random part
  bit                in_idle_on     = 1'b1;
  bit                out_idle_on    = 1'b1;

  function automatic void note_hit(smbw_pkg::kind_e k, logic [15:0] off);
    hit_t h;
    h.kind   = k;
    h.offset = off;
    byte_hits.push_back(h);
  endfunction

  function automatic void clear_walk();
    walk_pos     = '0;
    walk_phase   = WALK_TYPE;
    fmt_left     = '0;
    prev_zero    = 1'b0;
    string_count = 8'd1;
    in_match     = 1'b0;
    struct_found = 1'b0;
    string_done  = 1'b0;
  endfunction

  task automatic walk_table_byte(input logic [7:0] b, input logic last);
    byte_hits.delete();
    if (last) begin
      // end of table closes whatever search is open
      if (!struct_found) begin
        if (walk_phase == WALK_TYPE && b == target_type_q) begin
          note_hit(smbw_pkg::KIND_STRUCT_FOUND, walk_pos);
          note_hit(smbw_pkg::KIND_STRING_ABSENT, '0);
        end else begin
          note_hit(smbw_pkg::KIND_STRUCT_MISSING, '0);
        end
      end else if (!string_done) begin
        note_hit(smbw_pkg::KIND_STRING_ABSENT, '0);
      end
      clear_walk();
    end else begin
      case (walk_phase)
        WALK_TYPE: begin
          in_match = !struct_found && (b == target_type_q);
          if (in_match) begin
            note_hit(smbw_pkg::KIND_STRUCT_FOUND, walk_pos);
            struct_found = 1'b1;
          end
          walk_phase = WALK_LENGTH;
        end
        WALK_LENGTH: begin
          // length counts the header; 2 or below means strings follow at once
          fmt_left     = (b > 8'd2) ? b - 8'd2 : 8'd0;
          walk_phase   = (fmt_left != 0) ? WALK_FORMATTED : WALK_STRINGS;
          prev_zero    = 1'b0;
          string_count = 8'd1;
        end
        WALK_FORMATTED: begin
          fmt_left = fmt_left - 8'd1;
          if (fmt_left == 0) walk_phase = WALK_STRINGS;
        end
        WALK_STRINGS: begin
          if (in_match) begin
            if (prev_zero && b == 8'd0) begin
              note_hit(smbw_pkg::KIND_STRING_ABSENT, '0);
              string_done = 1'b1;
              walk_phase  = WALK_DONE;
            end else begin
              if (prev_zero && string_count != 8'd255) string_count = string_count + 8'd1;
              if (string_count == string_index_q) begin
                note_hit(smbw_pkg::KIND_STRING_FOUND, walk_pos);
                string_done = 1'b1;
                walk_phase  = WALK_DONE;
              end else begin
                prev_zero = (b == 8'd0);
              end
            end
          end else if (prev_zero && b == 8'd0) begin
            walk_phase = WALK_TYPE;
          end else begin
            prev_zero = (b == 8'd0);
          end
        end
        default: ;
      endcase
      walk_pos = walk_pos + 16'd1;
    end
  endtask

  function automatic void expect_result(smbw_pkg::kind_e k, logic [15:0] off, logic fin);
    smbw_pkg::result_t r;
    r.kind      = k;
    r.offset    = off;
    r.final_res = fin;
    expected_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Byte sender; entered and left at a falling edge
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic last, input bit use_model);
    int unsigned gap;
    gap = in_idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    fed_bytes++;
    walk_table_byte(b, last);
    if (use_model) begin
      foreach (byte_hits[i])
        expect_result(byte_hits[i].kind, byte_hits[i].offset, i == byte_hits.size() - 1);
    end
    @(negedge clk_i);
  endtask

  // Register write: the walker has to be idle, so drain everything first.
  task automatic cfg_write(input logic [7:0] idx, input logic [7:0] val);
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    // bytes with no result may still be in the pipe
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == smbw_pkg::REG_TARGET_TYPE) target_type_q = val;
    else if (idx == smbw_pkg::REG_STRING_INDEX) string_index_q = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_cfg();
    logic [7:0] val;
    bit         pick_index;
    pick_index = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0:       val = 8'd0;
      1:       val = 8'd255;
      default: val = pick_index ? 8'($urandom_range(0, 4)) : 8'($urandom_range(0, 255));
    endcase
    cfg_write(pick_index ? smbw_pkg::REG_STRING_INDEX : smbw_pkg::REG_TARGET_TYPE, val);
  endtask

  // Mostly well-formed tables with random content; some cut short or noisy.
  task automatic send_random_table();
    logic [7:0]  tbl[$];
    int unsigned n_struct, len, n_str, s_len, cut, style, room;
    n_struct = $urandom_range(1, 4);
    for (int unsigned s = 0; s < n_struct; s++) begin
      tbl.push_back(($urandom_range(0, 2) == 0) ? target_type_q : 8'($urandom_range(0, 255)));
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
      tbl.push_back(8'(len));
      for (int unsigned k = 2; k < len; k++) tbl.push_back(8'($urandom_range(0, 255)));
      // now and then enough strings to hit the top of the index range
      n_str = ($urandom_range(0, 49) == 0) ? $urandom_range(250, 260) : $urandom_range(0, 4);
      if (n_str == 0) tbl.push_back(8'd0);
      for (int unsigned k = 0; k < n_str; k++) begin
        s_len = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 5);
        for (int unsigned c = 0; c < s_len; c++) tbl.push_back(8'($urandom_range(1, 255)));
        tbl.push_back(8'd0);
      end
      tbl.push_back(8'd0);
    end
    style = $urandom_range(0, 9);
    if (style == 7) begin
      // truncated: string set or header left open at the last byte
      cut = $urandom_range(1, tbl.size());
      while (tbl.size() > cut) void'(tbl.pop_back());
    end else if (style == 8) begin
      repeat ($urandom_range(1, 6)) tbl.push_back(8'($urandom_range(0, 255)));
    end else if (style == 9) begin
      tbl.delete();
      repeat ($urandom_range(1, 20)) tbl.push_back(8'($urandom_range(0, 255)));
    end
    // keep the run near its byte budget; a cut table still ends with tlast
    room = RANDOM_BYTES - fed_bytes;
    while (tbl.size() > room) void'(tbl.pop_back());
    foreach (tbl[i]) begin
      // a rare mid-table register write
      if ($urandom_range(0, 149) == 0) random_cfg();
      push_byte(tbl[i], i == tbl.size() - 1, 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random hold-off before each beat
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      hold = out_idle_on ? $urandom_range(0, 15) : 0;
      if (hold > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker and run limit
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    smbw_pkg::result_t want;
    bit                bad;
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat kind=%0d offset=%0d tlast=%0b",
                 $time, m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
        errors++;
      end else begin
        want = expected_results.pop_front();
        bad  = 1'b0;
        if (m_axis_tuser_o !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, m_axis_tuser_o);
          bad = 1'b1;
        end
        if (m_axis_tdata_o !== want.offset) begin
          $display("%0t: offset expected %0d actual %0d", $time, want.offset, m_axis_tdata_o);
          bad = 1'b1;
        end
        if (m_axis_tlast_o !== want.final_res) begin
          $display("%0t: tlast expected %0b actual %0b", $time, want.final_res, m_axis_tlast_o);
          bad = 1'b1;
        end
        if (bad) errors++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows[$];

  function automatic void row_byte(logic [7:0] b, logic last, int n_typed = -1,
                                   smbw_pkg::kind_e k0 = smbw_pkg::KIND_STRUCT_FOUND,
                                   logic [15:0] o0 = '0,
                                   smbw_pkg::kind_e k1 = smbw_pkg::KIND_STRING_ABSENT);
    dir_row_t r;
    r.is_cfg  = 1'b0;
    r.a       = b;
    r.d       = '0;
    r.last    = last;
    r.n_typed = n_typed;
    r.k0      = k0;
    r.o0      = o0;
    r.k1      = k1;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_cfg(logic [7:0] idx, logic [7:0] val);
    dir_row_t r;
    r.is_cfg  = 1'b1;
    r.a       = idx;
    r.d       = val;
    r.last    = 1'b0;
    r.n_typed = -1;
    r.k0      = smbw_pkg::KIND_STRUCT_FOUND;
    r.o0      = '0;
    r.k1      = smbw_pkg::KIND_STRUCT_FOUND;
    dir_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset registers (type 0, index 1): type 0 at offset 0, short length,
    // empty string set whose first zero is string 1
    row_byte(8'h00, 1'b0, 1, smbw_pkg::KIND_STRUCT_FOUND, 16'd0);
    row_byte(8'h01, 1'b0);
    row_byte(8'h00, 1'b0, 1, smbw_pkg::KIND_STRING_FOUND, 16'd2);
    row_byte(8'hFF, 1'b1);
    // type 255, index 0: skip one structure, match the second, index 0 runs
    // into the double zero
    row_cfg(smbw_pkg::REG_TARGET_TYPE, 8'hFF);
    row_cfg(smbw_pkg::REG_STRING_INDEX, 8'h00);
    row_byte(8'h01, 1'b0);
    row_byte(8'h04, 1'b0);
    row_byte(8'hAA, 1'b0);
    row_byte(8'h55, 1'b0);
    row_byte(8'h61, 1'b0);
    row_byte(8'h00, 1'b0);
    row_byte(8'h00, 1'b0);
    row_byte(8'hFF, 1'b0, 1, smbw_pkg::KIND_STRUCT_FOUND, 16'd7);
    row_byte(8'h02, 1'b0);
    row_byte(8'h41, 1'b0);
    row_byte(8'h00, 1'b0);
    row_byte(8'h42, 1'b0);
    row_byte(8'h00, 1'b0);
    row_byte(8'h00, 1'b0, 1, smbw_pkg::KIND_STRING_ABSENT, 16'd0);
    row_byte(8'h00, 1'b1);
    // match on a one-byte table: found, then absent on the same byte
    row_cfg(smbw_pkg::REG_TARGET_TYPE, 8'h80);
    row_cfg(smbw_pkg::REG_STRING_INDEX, 8'hFF);
    row_byte(8'h80, 1'b1, 2, smbw_pkg::KIND_STRUCT_FOUND, 16'd0, smbw_pkg::KIND_STRING_ABSENT);
    // no match, string set never closed before the last byte
    row_byte(8'h12, 1'b0);
    row_byte(8'h02, 1'b0);
    row_byte(8'h00, 1'b0);
    row_byte(8'h31, 1'b1, 1, smbw_pkg::KIND_STRUCT_MISSING, 16'd0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        cfg_write(dir_rows[i].a, dir_rows[i].d);
      end else begin
        if (dir_rows[i].n_typed >= 1)
          expect_result(dir_rows[i].k0, dir_rows[i].o0, dir_rows[i].n_typed == 1);
        if (dir_rows[i].n_typed == 2)
          expect_result(dir_rows[i].k1, 16'd0, 1'b1);
        push_byte(dir_rows[i].a, dir_rows[i].last, dir_rows[i].n_typed < 0);
      end
    end

    // random tables; register writes between them, idling mostly on
    fed_bytes = 0;
    while (fed_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) == 0) random_cfg();
      in_idle_on  = ($urandom_range(0, 4) != 0);
      out_idle_on = ($urandom_range(0, 4) != 0);
      send_random_table();
    end

    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
